[rtl/core/lmc_pkg.sv]
// ----------------------------------------------------------------------------
// lmc_pkg
// Shared codes, types and helpers for the two-lamp mode controller.
// ----------------------------------------------------------------------------
package lmc_pkg;

    localparam int NUM_LAMPS = 2;

    localparam int MODE_W   = 3;
    localparam int BRIGHT_W = 7;
    localparam int DELAY_W  = 31;
    localparam int ELAPSED_W = 32;
    localparam int DT_W     = 16;
    localparam int AMB_W    = 10;
    localparam int DUTY_W   = 8;

    // lamp mode codes
    localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ON     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DIM    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TIMER  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SENSOR = 3'd4;

    // register indexes (paddr[4:2])
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_LAMP0_MODE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LAMP1_MODE   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LAMP0_BRIGHT = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LAMP1_BRIGHT = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LAMP0_DELAY  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LAMP1_DELAY  = 3'd5;

    localparam logic [DUTY_W-1:0] DUTY_FULL = 8'd255;
    localparam logic [DUTY_W-1:0] DUTY_HALF = 8'd128;
    localparam logic [DUTY_W-1:0] DUTY_NONE = 8'd0;

    localparam logic [AMB_W-1:0] AMB_DARK = 10'd200;
    localparam logic [AMB_W-1:0] AMB_DIM  = 10'd500;

    // brightness * 255 / 100 as one multiply by 255 * ceil(2^19 / 100), then >> 19
    localparam int DIM_SHIFT = 19;
    localparam int DIM_RECIP_W = 21;
    localparam logic [DIM_RECIP_W-1:0] DIM_RECIP = 21'd1336965;
    localparam int DIM_PROD_W = BRIGHT_W + DIM_RECIP_W;

    typedef struct packed {
        logic                mode_we;
        logic [MODE_W-1:0]   mode_wdata;
        logic [BRIGHT_W-1:0] brightness;
        logic [DELAY_W-1:0]  delay;
    } lmc_lamp_cfg_t;

    typedef struct packed {
        logic              on;
        logic [DUTY_W-1:0] duty;
        logic [MODE_W-1:0] mode;
    } lmc_lamp_stat_t;

    function automatic logic [DUTY_W-1:0] dim_duty(input logic [BRIGHT_W-1:0] b);
        logic [DIM_PROD_W-1:0]           prod;
        logic [DIM_PROD_W-DIM_SHIFT-1:0] q;
        prod = DIM_PROD_W'(b) * DIM_PROD_W'(DIM_RECIP);
        q    = prod[DIM_PROD_W-1:DIM_SHIFT];
        if (q > (DIM_PROD_W-DIM_SHIFT)'(DUTY_FULL)) begin
            return DUTY_FULL;
        end
        return q[DUTY_W-1:0];
    endfunction

endpackage

[rtl/core/lamp_mode_controller_unit.sv]
// ----------------------------------------------------------------------------
// lamp_mode_controller_unit
// Two-lamp mode controller with a stream update port and APB registers.
// ----------------------------------------------------------------------------
// Each request on the s_ channel is one update pass for both lamps; each pass
// yields exactly one result on the m_ channel. A request is captured in an
// input register; once the result register is free or being emptied, both
// lamps evaluate their mode and update their state registers, which also
// serve as the result register. One request is taken every cycle as long as
// m_tready keeps up; the limit is the single result register, so a stalled
// result blocks only once the input register is also full. Registers: 0/1
// lamp mode (writing clears that lamp's elapsed time), 2/3 brightness in
// percent, 4/5 timer delay in ms, at byte address 4*i.
// ----------------------------------------------------------------------------
module lamp_mode_controller_unit
    import lmc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [15:0] ms_since_last, [25:16] ambient_level, [31:26] zero
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // m_tdata: [0] lamp0_on, [8:1] lamp0_duty, [9] lamp1_on, [17:10] lamp1_duty,
    //          [20:18] lamp0_state, [23:21] lamp1_state
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic             in_valid_reg;
    logic [DT_W-1:0]  dt_reg;
    logic [AMB_W-1:0] amb_reg;
    logic             out_valid_reg;
    logic             advance;

    lmc_lamp_cfg_t  lamp_cfg  [NUM_LAMPS];
    lmc_lamp_stat_t lamp_stat [NUM_LAMPS];

    // a pass runs when the result slot is free or being emptied this cycle
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            dt_reg  <= s_tdata[DT_W-1:0];
            amb_reg <= s_tdata[DT_W+AMB_W-1:DT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    lmc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .lamp_stat (lamp_stat),
        .lamp_cfg  (lamp_cfg)
    );

    for (genvar k = 0; k < NUM_LAMPS; k++) begin : g_lamp
        lmc_lamp u_lamp (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cfg     (lamp_cfg[k]),
            .step    (advance),
            .dt      (dt_reg),
            .ambient (amb_reg),
            .stat    (lamp_stat[k])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {lamp_stat[1].mode, lamp_stat[0].mode,
                       lamp_stat[1].duty, lamp_stat[1].on,
                       lamp_stat[0].duty, lamp_stat[0].on};

`ifndef ASSERT_OFF
    a_pass_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("pass ran but no result was raised");
    a_request_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("held request was dropped");
    a_result_retired: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !advance |=> !m_tvalid)
        else $error("delivered result shown again");
`endif

endmodule

[rtl/core/lmc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// lmc_cfg_regs
// APB register file: mode write strobes, brightness and delay registers.
// ----------------------------------------------------------------------------
module lmc_cfg_regs
    import lmc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  lmc_lamp_stat_t       lamp_stat [NUM_LAMPS],
    output lmc_lamp_cfg_t        lamp_cfg  [NUM_LAMPS]
);

    logic [BRIGHT_W-1:0]  bright_reg [NUM_LAMPS];
    logic [DELAY_W-1:0]   delay_reg  [NUM_LAMPS];
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bright_reg[0] <= '0;
            bright_reg[1] <= '0;
            delay_reg[0]  <= '0;
            delay_reg[1]  <= '0;
        end else if (wr_en) begin
            if (idx == REG_LAMP0_BRIGHT) bright_reg[0] <= pwdata[BRIGHT_W-1:0];
            if (idx == REG_LAMP1_BRIGHT) bright_reg[1] <= pwdata[BRIGHT_W-1:0];
            if (idx == REG_LAMP0_DELAY)  delay_reg[0]  <= pwdata[DELAY_W-1:0];
            if (idx == REG_LAMP1_DELAY)  delay_reg[1]  <= pwdata[DELAY_W-1:0];
        end
    end

    always_comb begin
        lamp_cfg[0].mode_we    = wr_en && (idx == REG_LAMP0_MODE);
        lamp_cfg[0].mode_wdata = pwdata[MODE_W-1:0];
        lamp_cfg[0].brightness = bright_reg[0];
        lamp_cfg[0].delay      = delay_reg[0];
        lamp_cfg[1].mode_we    = wr_en && (idx == REG_LAMP1_MODE);
        lamp_cfg[1].mode_wdata = pwdata[MODE_W-1:0];
        lamp_cfg[1].brightness = bright_reg[1];
        lamp_cfg[1].delay      = delay_reg[1];
    end

    always_comb begin
        unique case (idx)
            REG_LAMP0_MODE:   prdata = 32'(lamp_stat[0].mode);
            REG_LAMP1_MODE:   prdata = 32'(lamp_stat[1].mode);
            REG_LAMP0_BRIGHT: prdata = 32'(bright_reg[0]);
            REG_LAMP1_BRIGHT: prdata = 32'(bright_reg[1]);
            REG_LAMP0_DELAY:  prdata = 32'(delay_reg[0]);
            REG_LAMP1_DELAY:  prdata = 32'(delay_reg[1]);
            default:          prdata = '0;
        endcase
    end

endmodule

[rtl/core/lmc_lamp.sv]
// ----------------------------------------------------------------------------
// lmc_lamp
// One lamp: mode, elapsed time, switch and duty registers and the pass logic.
// ----------------------------------------------------------------------------
module lmc_lamp
    import lmc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  lmc_lamp_cfg_t       cfg,
    input  logic                step,
    input  logic [DT_W-1:0]     dt,
    input  logic [AMB_W-1:0]    ambient,
    output lmc_lamp_stat_t      stat
);

    logic [MODE_W-1:0]    mode_reg,    mode_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic                 on_reg,      on_next;
    logic [DUTY_W-1:0]    duty_reg,    duty_next;

    logic [ELAPSED_W:0]   sum;
    logic [ELAPSED_W-1:0] elapsed_sat;
    logic                 expired;

    assign sum         = {1'b0, elapsed_reg} + (ELAPSED_W+1)'(dt);
    assign elapsed_sat = sum[ELAPSED_W] ? '1 : sum[ELAPSED_W-1:0];
    assign expired     = elapsed_sat >= ELAPSED_W'(cfg.delay);

    always_comb begin
        mode_next    = mode_reg;
        elapsed_next = elapsed_reg;
        on_next      = on_reg;
        duty_next    = duty_reg;
        unique case (mode_reg)
            MODE_OFF: begin
                on_next   = 1'b0;
                duty_next = DUTY_NONE;
            end
            MODE_ON: begin
                on_next   = 1'b1;
                duty_next = DUTY_FULL;
            end
            MODE_DIM: begin
                duty_next = dim_duty(cfg.brightness);
            end
            MODE_TIMER: begin
                elapsed_next = elapsed_sat;
                if (expired) begin
                    mode_next = MODE_OFF;
                    on_next   = 1'b0;
                    duty_next = DUTY_NONE;
                end else begin
                    on_next = 1'b1;
                end
            end
            MODE_SENSOR: begin
                if (ambient < AMB_DARK) begin
                    duty_next = DUTY_FULL;
                end else if (ambient < AMB_DIM) begin
                    duty_next = DUTY_HALF;
                end else begin
                    duty_next = DUTY_NONE;
                end
            end
            default: begin
                // undefined modes leave the pins alone
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_OFF;
            elapsed_reg <= '0;
            on_reg      <= 1'b0;
            duty_reg    <= '0;
        end else if (cfg.mode_we) begin
            mode_reg    <= cfg.mode_wdata;
            elapsed_reg <= '0;
        end else if (step) begin
            mode_reg    <= mode_next;
            elapsed_reg <= elapsed_next;
            on_reg      <= on_next;
            duty_reg    <= duty_next;
        end
    end

    assign stat.on   = on_reg;
    assign stat.duty = duty_reg;
    assign stat.mode = mode_reg;

`ifndef ASSERT_OFF
    a_off_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(step) && !$past(cfg.mode_we) && mode_reg == MODE_OFF
            |-> !on_reg && duty_reg == DUTY_NONE)
        else $error("lamp in off mode after a pass but pins not cleared");
    a_on_full: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(step) && !$past(cfg.mode_we) && $past(mode_reg) == MODE_ON
            |-> on_reg && duty_reg == DUTY_FULL && mode_reg == MODE_ON)
        else $error("lamp in on mode not driven full");
    a_timer_lit: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !cfg.mode_we && mode_reg == MODE_TIMER && !expired
            |=> on_reg && mode_reg == MODE_TIMER)
        else $error("running timer did not hold the lamp on");
`endif

endmodule

[tb/sv/tb_lamp_mode_controller_unit.sv]
// ----------------------------------------------------------------------------
// tb_lamp_mode_controller_unit
// Self-checking bench for the two-lamp mode controller. Update passes go in on
// the s_ stream, and lamp settings are written over APB while the block is
// idle. A local model of both lamps predicts each result, which is then
// compared field by field. Directed cases come first, then random setups
// under three idling profiles and one long result stall.
// ----------------------------------------------------------------------------
module tb_lamp_mode_controller_unit;
    import lmc_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int STALL_CYCLES   = 400;
    localparam int SETTLE_CYCLES  = 4;

    // addresses past the register list, and mode codes with no meaning
    localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;
    localparam logic [MODE_W-1:0] MODE_SPARE_LO  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_MID = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI  = 3'd7;
    localparam logic [DELAY_W-1:0] DELAY_MAX     = 31'h7FFF_FFFF;

    // packed so that lamp0_on lands in bit 0, as on m_tdata
    typedef struct packed {
        logic [MODE_W-1:0] lamp1_state;
        logic [MODE_W-1:0] lamp0_state;
        logic [DUTY_W-1:0] lamp1_duty;
        logic              lamp1_on;
        logic [DUTY_W-1:0] lamp0_duty;
        logic              lamp0_on;
    } lamp_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // lamp model state and settings
    logic [MODE_W-1:0]    lamp_mode    [NUM_LAMPS];
    logic [ELAPSED_W-1:0] lamp_elapsed [NUM_LAMPS];
    logic                 lamp_switch  [NUM_LAMPS];
    logic [DUTY_W-1:0]    lamp_duty    [NUM_LAMPS];
    logic [BRIGHT_W-1:0]  lamp_bright  [NUM_LAMPS];
    logic [DELAY_W-1:0]   lamp_delay   [NUM_LAMPS];

    lamp_result_t due_results[$];
    lamp_result_t want_r;
    lamp_result_t got_r;

    int fail_count     = 0;
    int passes_sent    = 0;
    int results_seen   = 0;
    int reg_writes     = 0;
    int timer_expiries = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int stall_seq_req  = 0;
    int stall_seq_seen = 0;
    int stall_left     = 0;
    int quiet_cycles   = 0;

    lamp_mode_controller_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------
    // lamp model
    // ------------------------------------------------------------------
    function automatic void clear_lamps();
        for (int k = 0; k < NUM_LAMPS; k++) begin
            lamp_mode[k]    = MODE_OFF;
            lamp_elapsed[k] = '0;
            lamp_switch[k]  = 1'b0;
            lamp_duty[k]    = DUTY_NONE;
            lamp_bright[k]  = '0;
            lamp_delay[k]   = '0;
        end
    endfunction

    function automatic void store_setting(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
        case (idx)
            REG_LAMP0_MODE: begin
                lamp_mode[0]    = value[MODE_W-1:0];
                lamp_elapsed[0] = '0;
            end
            REG_LAMP1_MODE: begin
                lamp_mode[1]    = value[MODE_W-1:0];
                lamp_elapsed[1] = '0;
            end
            REG_LAMP0_BRIGHT: lamp_bright[0] = value[BRIGHT_W-1:0];
            REG_LAMP1_BRIGHT: lamp_bright[1] = value[BRIGHT_W-1:0];
            REG_LAMP0_DELAY:  lamp_delay[0]  = value[DELAY_W-1:0];
            REG_LAMP1_DELAY:  lamp_delay[1]  = value[DELAY_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic lamp_result_t step_lamps(logic [DT_W-1:0] dt, logic [AMB_W-1:0] amb);
        lamp_result_t r;
        logic [ELAPSED_W:0] sum;
        int unsigned dim;
        for (int k = 0; k < NUM_LAMPS; k++) begin
            case (lamp_mode[k])
                MODE_OFF: begin
                    lamp_switch[k] = 1'b0;
                    lamp_duty[k]   = DUTY_NONE;
                end
                MODE_ON: begin
                    lamp_switch[k] = 1'b1;
                    lamp_duty[k]   = DUTY_FULL;
                end
                MODE_DIM: begin
                    dim = lamp_bright[k] * 255 / 100;
                    lamp_duty[k] = (dim > 255) ? DUTY_FULL : dim[DUTY_W-1:0];
                end
                MODE_TIMER: begin
                    sum = {1'b0, lamp_elapsed[k]} + (ELAPSED_W+1)'(dt);
                    lamp_elapsed[k] = sum[ELAPSED_W] ? '1 : sum[ELAPSED_W-1:0];
                    if (lamp_elapsed[k] >= {1'b0, lamp_delay[k]}) begin
                        lamp_mode[k]   = MODE_OFF;
                        lamp_switch[k] = 1'b0;
                        lamp_duty[k]   = DUTY_NONE;
                        timer_expiries++;
                    end else begin
                        lamp_switch[k] = 1'b1;
                    end
                end
                MODE_SENSOR: begin
                    if (amb < AMB_DARK) lamp_duty[k] = DUTY_FULL;
                    else if (amb < AMB_DIM) lamp_duty[k] = DUTY_HALF;
                    else lamp_duty[k] = DUTY_NONE;
                end
                default: ;  // unknown mode leaves both pins as they are
            endcase
        end
        r.lamp0_on    = lamp_switch[0];
        r.lamp0_duty  = lamp_duty[0];
        r.lamp1_on    = lamp_switch[1];
        r.lamp1_duty  = lamp_duty[1];
        r.lamp0_state = lamp_mode[0];
        r.lamp1_state = lamp_mode[1];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // monitors
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            due_results.push_back(step_lamps(s_tdata[DT_W-1:0], s_tdata[DT_W +: AMB_W]));
            passes_sent++;
        end
    end

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_r = lamp_result_t'(m_tdata);
            if (due_results.size() == 0) begin
                $error("result with nothing pending: m_tdata 0x%06h", m_tdata);
                fail_count++;
            end else begin
                want_r = due_results.pop_front();
                check_field("lamp0_on",    32'(want_r.lamp0_on),    32'(got_r.lamp0_on));
                check_field("lamp0_duty",  32'(want_r.lamp0_duty),  32'(got_r.lamp0_duty));
                check_field("lamp1_on",    32'(want_r.lamp1_on),    32'(got_r.lamp1_on));
                check_field("lamp1_duty",  32'(want_r.lamp1_duty),  32'(got_r.lamp1_duty));
                check_field("lamp0_state", 32'(want_r.lamp0_state), 32'(got_r.lamp0_state));
                check_field("lamp1_state", 32'(want_r.lamp1_state), 32'(got_r.lamp1_state));
            end
            results_seen++;
        end
    end

    // result side: random back-pressure, or a long hold when asked for
    always @(negedge aclk) begin
        if (stall_seq_req != stall_seq_seen) begin
            stall_seq_seen = stall_seq_req;
            stall_left     = STALL_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pwrite && pready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles, %0d results pending",
                     WATCHDOG_LIMIT, due_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_pass(logic [DT_W-1:0] dt, logic [AMB_W-1:0] amb);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, amb, dt};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
    endtask

    // stop offering requests and let every pending result come out
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        store_setting(idx, value);
        reg_writes++;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_state();
        send_pass('0, '0);
        send_pass('1, '1);
        drain_results();
    endtask

    task automatic test_on_and_sensor();
        reg_write(REG_LAMP0_MODE, 32'(MODE_ON));
        reg_write(REG_LAMP1_MODE, 32'(MODE_SENSOR));
        send_pass(16'd0, 10'd0);
        send_pass(16'd1, 10'd199);
        send_pass(16'hFFFF, 10'd200);
        send_pass(16'd7, 10'd499);
        send_pass(16'd0, 10'd500);
        send_pass(16'd3, 10'd1023);
        drain_results();
    endtask

    task automatic test_dimming();
        // lamp 0 keeps the switch level left by on mode
        reg_write(REG_LAMP0_BRIGHT, 32'd100);
        reg_write(REG_LAMP1_BRIGHT, 32'd127);
        reg_write(REG_LAMP0_MODE, 32'(MODE_DIM));
        reg_write(REG_LAMP1_MODE, 32'(MODE_DIM));
        send_pass(16'd10, 10'd300);
        drain_results();
        reg_write(REG_LAMP0_BRIGHT, 32'd1);
        reg_write(REG_LAMP1_BRIGHT, 32'd101);
        send_pass(16'd10, 10'd300);
        drain_results();
        reg_write(REG_LAMP0_BRIGHT, 32'd0);
        reg_write(REG_LAMP1_BRIGHT, 32'd99);
        send_pass(16'd10, 10'd300);
        drain_results();
    endtask

    task automatic test_timer();
        // zero delay runs out at once, 1000 ms runs out on the third pass
        reg_write(REG_LAMP0_DELAY, 32'd0);
        reg_write(REG_LAMP1_DELAY, 32'd1000);
        reg_write(REG_LAMP0_MODE, 32'(MODE_TIMER));
        reg_write(REG_LAMP1_MODE, 32'(MODE_TIMER));
        repeat (3) send_pass(16'd400, 10'd0);
        drain_results();
        // longest delay holds; elapsed equal to delay counts as expired
        reg_write(REG_LAMP0_DELAY, 32'(DELAY_MAX));
        reg_write(REG_LAMP1_DELAY, 32'd65535);
        reg_write(REG_LAMP0_MODE, 32'(MODE_TIMER));
        reg_write(REG_LAMP1_MODE, 32'(MODE_TIMER));
        send_pass(16'hFFFF, 10'd0);
        drain_results();
    endtask

    task automatic test_undefined_modes();
        reg_write(REG_LAMP0_MODE, 32'(MODE_SPARE_LO));
        reg_write(REG_LAMP1_MODE, 32'(MODE_SPARE_HI));
        send_pass(16'd5, 10'd100);
        drain_results();
        reg_write(REG_LAMP0_MODE, 32'(MODE_SPARE_MID));
        send_pass(16'd5, 10'd900);
        drain_results();
    endtask

    task automatic test_stray_register();
        reg_write(REG_SPARE_A, '1);
        reg_write(REG_SPARE_B, '1);
        send_pass(16'd1, 10'd1);
        drain_results();
    endtask

    task automatic pick_setup();
        logic [DELAY_W-1:0] dly;
        int pick;
        for (int k = 0; k < NUM_LAMPS; k++) begin
            if ($urandom_range(1) == 1) begin
                reg_write(k ? REG_LAMP1_BRIGHT : REG_LAMP0_BRIGHT, $urandom_range(127));
            end
            if ($urandom_range(1) == 1) begin
                pick = $urandom_range(99);
                if (pick < 20) dly = DELAY_W'($urandom_range(50));
                else if (pick < 60) dly = DELAY_W'($urandom_range(5000));
                else if (pick < 80) dly = DELAY_W'($urandom_range(200000));
                else if (pick < 90) dly = DELAY_MAX;
                else dly = DELAY_W'($urandom());
                reg_write(k ? REG_LAMP1_DELAY : REG_LAMP0_DELAY, 32'(dly));
            end
            pick = $urandom_range(99);
            if (pick < 8) begin
                reg_write(k ? REG_LAMP1_MODE : REG_LAMP0_MODE,
                          $urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
            end else if (pick < 45) begin
                reg_write(k ? REG_LAMP1_MODE : REG_LAMP0_MODE, 32'(MODE_TIMER));
            end else begin
                reg_write(k ? REG_LAMP1_MODE : REG_LAMP0_MODE, $urandom_range(MODE_SENSOR));
            end
        end
    endtask

    task automatic test_random_phase(int send_pct, int recv_pct, int pass_count);
        logic [DT_W-1:0]  dt;
        logic [AMB_W-1:0] amb;
        int done;
        int seg;
        int pick;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        done = 0;
        while (done < pass_count) begin
            pick_setup();
            seg = $urandom_range(60, 20);
            for (int i = 0; i < seg; i++) begin
                pick = $urandom_range(99);
                if (pick < 60) dt = DT_W'($urandom_range(300));
                else if (pick < 85) dt = DT_W'($urandom());
                else dt = ($urandom_range(1) == 1) ? '1 : '0;
                pick = $urandom_range(99);
                if (pick < 15) amb = AMB_W'($urandom_range(205, 195));
                else if (pick < 30) amb = AMB_W'($urandom_range(505, 495));
                else amb = AMB_W'($urandom());
                send_pass(dt, amb);
            end
            done += seg;
            drain_results();
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        reg_write(REG_LAMP0_MODE, 32'(MODE_ON));
        reg_write(REG_LAMP1_MODE, 32'(MODE_SENSOR));
        stall_seq_req++;
        for (int i = 0; i < 40; i++) begin
            send_pass(DT_W'($urandom()), AMB_W'($urandom()));
        end
        drain_results();
    endtask

    initial begin
        clear_lamps();
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 28;
        recv_idle_pct = 50;
        test_reset_state();
        test_on_and_sensor();
        test_dimming();
        test_timer();
        test_undefined_modes();
        test_stray_register();

        test_random_phase(28, 50, 470);
        test_random_phase(50, 28, 470);
        test_backpressure();
        test_random_phase(0, 0, 460);

        drain_results();
        repeat (10) @(posedge aclk);
        $display("covered %0d update passes, %0d results, %0d register writes",
                 passes_sent, results_seen, reg_writes);
        $display("all five modes plus unknown codes, %0d timer expiries, %0d-cycle output stall",
                 timer_expiries, STALL_CYCLES);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/lmc_pkg.sv
rtl/core/lmc_cfg_regs.sv
rtl/core/lmc_lamp.sv
rtl/core/lamp_mode_controller_unit.sv
tb/sv/tb_lamp_mode_controller_unit.sv
